// ----- rtl/gvpc_pkg.sv -----
// ----------------------------------------------------------------------------
// gvpc_pkg
// Shared types, widths and constants of the gripper velocity PID current unit.
// ----------------------------------------------------------------------------
package gvpc_pkg;

  localparam int POS_W       = 32;
  localparam int GAIN_W      = 24;
  localparam int LIMIT_W     = 15;
  localparam int DBAND_W     = 16;
  localparam int CURRENT_W   = 16;
  localparam int INTEG_W     = 17;
  localparam int FRAC_BITS   = 16;
  localparam int MUL_X_W     = POS_W + 1;                      // difference of two errors
  localparam int MUL_P_W     = GAIN_W + MUL_X_W;               // exact magnitude product
  localparam int MUL_RES_W   = MUL_P_W - FRAC_BITS + 1;        // signed, after the shift
  localparam int ACC_W       = MUL_RES_W + 2;                  // sum of three terms
  localparam int SUM_W       = POS_W + 2;                      // integral plus error
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;

  localparam int INTEGRAL_LIMIT   = 50000;
  localparam int DEAD_ZONE_OFFSET = 35;
  localparam logic [DBAND_W-1:0] DEADBAND_RESET = DBAND_W'(20);

  // configuration register indices
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND      = CFG_IDX_W'(5);

  typedef logic signed [POS_W-1:0]     pos_t;
  typedef logic signed [GAIN_W-1:0]    gain_t;
  typedef logic        [LIMIT_W-1:0]   limit_t;
  typedef logic        [DBAND_W-1:0]   dband_t;
  typedef logic signed [CURRENT_W-1:0] current_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic        [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic signed [MUL_X_W-1:0]   mul_x_t;
  typedef logic signed [MUL_RES_W-1:0] mul_res_t;
  typedef logic signed [ACC_W-1:0]     acc_t;

  typedef struct packed {
    gain_t  velocity_gain;
    gain_t  prop_gain;
    gain_t  integ_gain;
    gain_t  deriv_gain;
    limit_t drive_limit;
    dband_t deadband;
  } cfg_t;

  // saturate a wide signed value to the 32-bit signed range
  function automatic pos_t sat32(input acc_t v);
    acc_t hi;
    acc_t lo;
    hi = ACC_W'({1'b0, {(POS_W-1){1'b1}}});
    lo = -hi - ACC_W'(1);
    if (v > hi)      sat32 = pos_t'(hi);
    else if (v < lo) sat32 = pos_t'(lo);
    else             sat32 = pos_t'(v);
  endfunction

endpackage

// ----- rtl/gvpc_in_if.sv -----
// ----------------------------------------------------------------------------
// gvpc_in_if
// Input channel: one control tick of positions and velocity.
// ----------------------------------------------------------------------------
interface gvpc_in_if import gvpc_pkg::*; ();
  logic valid;
  logic ready;
  pos_t goal_position;
  pos_t measured_position;
  pos_t measured_velocity;

  modport source (output valid, output goal_position, output measured_position,
                  output measured_velocity, input ready);
  modport sink   (input valid, input goal_position, input measured_position,
                  input measured_velocity, output ready);
endinterface

// ----- rtl/gvpc_out_if.sv -----
// ----------------------------------------------------------------------------
// gvpc_out_if
// Result channel: one drive current per tick.
// ----------------------------------------------------------------------------
interface gvpc_out_if import gvpc_pkg::*; ();
  logic     valid;
  logic     ready;
  current_t drive_current;

  modport source (output valid, output drive_current, input ready);
  modport sink   (input valid, input drive_current, output ready);
endinterface

// ----- rtl/gvpc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// gvpc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gvpc_cfg_if import gvpc_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/gvpc_regs.sv -----
// ----------------------------------------------------------------------------
// gvpc_regs
// Configuration register file: gains, current limit and deadband.
// ----------------------------------------------------------------------------
module gvpc_regs import gvpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  gvpc_cfg_if.sink    cfg_ch,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.velocity_gain <= '0;
      cfg_r.prop_gain     <= '0;
      cfg_r.integ_gain    <= '0;
      cfg_r.deriv_gain    <= '0;
      cfg_r.drive_limit   <= '0;
      cfg_r.deadband      <= DEADBAND_RESET;
    end else if (cfg_ch.valid) begin
      // unknown indices drop the transfer
      unique case (cfg_ch.index)
        REG_VELOCITY_GAIN: cfg_r.velocity_gain <= gain_t'(cfg_ch.data[GAIN_W-1:0]);
        REG_PROP_GAIN:     cfg_r.prop_gain     <= gain_t'(cfg_ch.data[GAIN_W-1:0]);
        REG_INTEG_GAIN:    cfg_r.integ_gain    <= gain_t'(cfg_ch.data[GAIN_W-1:0]);
        REG_DERIV_GAIN:    cfg_r.deriv_gain    <= gain_t'(cfg_ch.data[GAIN_W-1:0]);
        REG_CURRENT_LIMIT: cfg_r.drive_limit   <= cfg_ch.data[LIMIT_W-1:0];
        REG_DEADBAND:      cfg_r.deadband      <= cfg_ch.data[DBAND_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/gvpc_mulq.sv -----
// ----------------------------------------------------------------------------
// gvpc_mulq
// Shared Q8.16 multiplier: gain times value, shifted down toward zero.
// Three stages: magnitudes, product, shift and sign.
// ----------------------------------------------------------------------------
module gvpc_mulq import gvpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  gain_t    gain,
  input  mul_x_t   x,
  output logic     done,
  output mul_res_t res
);

  logic [GAIN_W-1:0]            mg_r;
  logic [MUL_X_W-1:0]           mx_r;
  logic [MUL_P_W-1:0]           p_r;
  logic                         neg1_r;
  logic                         neg2_r;
  logic                         v1_r;
  logic                         v2_r;
  logic                         done_r;
  mul_res_t                     res_r;
  logic [MUL_P_W-FRAC_BITS-1:0] q;

  assign q    = p_r[MUL_P_W-1:FRAC_BITS];
  assign done = done_r;
  assign res  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    mg_r   <= gain[GAIN_W-1] ? GAIN_W'(-gain) : GAIN_W'(gain);
    mx_r   <= x[MUL_X_W-1] ? MUL_X_W'(-x) : MUL_X_W'(x);
    neg1_r <= gain[GAIN_W-1] ^ x[MUL_X_W-1];
    p_r    <= MUL_P_W'(mg_r) * MUL_P_W'(mx_r);
    neg2_r <= neg1_r;
    res_r  <= neg2_r ? -mul_res_t'({1'b0, q}) : mul_res_t'({1'b0, q});
  end

endmodule

// ----- rtl/gripper_velocity_pid_current_unit.sv -----
// One item at a time: the single shared multiplier (three stages) runs four products
//   under the sequencer, and input is taken only in idle.
// A waiting result does not block the next input transfer; it holds the next result.
// Reset (synchronous, rst_n low): idle, output empty, integral and previous error zero,
//   gains and current limit zero, deadband 20.
// ----------------------------------------------------------------------------
// gripper_velocity_pid_current_unit
// Position-to-velocity PID current controller with deadband and anti-windup.
// ----------------------------------------------------------------------------
module gripper_velocity_pid_current_unit import gvpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  gvpc_in_if.sink     in_ch,
  gvpc_out_if.source  out_ch,
  gvpc_cfg_if.sink    cfg_ch
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PERR  = 4'd1;
  localparam logic [3:0] S_BAND1 = 4'd2;
  localparam logic [3:0] S_MULV  = 4'd3;
  localparam logic [3:0] S_VERR  = 4'd4;
  localparam logic [3:0] S_BAND2 = 4'd5;
  localparam logic [3:0] S_INTEG = 4'd6;
  localparam logic [3:0] S_MULI  = 4'd7;
  localparam logic [3:0] S_MULD  = 4'd8;
  localparam logic [3:0] S_ACCW  = 4'd9;
  localparam logic [3:0] S_OFFS  = 4'd10;
  localparam logic [3:0] S_SAT   = 4'd11;

  function automatic logic in_band(input pos_t e, input dband_t db);
    logic [POS_W-1:0] a;
    a = e[POS_W-1] ? POS_W'(-e) : POS_W'(e);
    in_band = (a <= POS_W'(db));
  endfunction

  cfg_t     cfg;
  logic [3:0] state_r;
  pos_t     tpos_r, mpos_r, mvel_r;
  pos_t     perr_r, tvel_r, verr_r, err_r, prev_r;
  logic signed [INTEG_W-1:0] integ_r;
  mul_x_t   diff_r;
  logic     band_r;
  acc_t     acc_r;
  acc_t     u_r;
  logic [1:0] cnt_r;
  logic     out_valid_r;
  current_t out_drive_r;

  logic     mul_start;
  gain_t    mul_gain;
  mul_x_t   mul_x;
  logic     mul_done;
  mul_res_t mul_res;

  logic signed [SUM_W-1:0] integ_sum;
  acc_t     lim;
  acc_t     u_sat;

  gvpc_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  gvpc_mulq u_mulq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .gain  (mul_gain),
    .x     (mul_x),
    .done  (mul_done),
    .res   (mul_res)
  );

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.drive_current = out_drive_r;

  // operand select for the shared multiplier
  always_comb begin
    mul_start = 1'b0;
    mul_gain  = cfg.velocity_gain;
    mul_x     = mul_x_t'(perr_r);
    unique case (state_r)
      S_BAND1: begin
        mul_start = 1'b1;
      end
      S_INTEG: begin
        mul_start = 1'b1;
        mul_gain  = cfg.prop_gain;
        mul_x     = mul_x_t'(err_r);
      end
      S_MULI: begin
        mul_start = 1'b1;
        mul_gain  = cfg.integ_gain;
        mul_x     = mul_x_t'(integ_r);
      end
      S_MULD: begin
        mul_start = 1'b1;
        mul_gain  = cfg.deriv_gain;
        mul_x     = diff_r;
      end
      default: ;
    endcase
  end

  assign integ_sum = SUM_W'(integ_r) + SUM_W'(err_r);
  assign lim       = acc_t'({1'b0, cfg.drive_limit});

  always_comb begin
    if (u_r > lim)       u_sat = lim;
    else if (u_r < -lim) u_sat = -lim;
    else                 u_sat = u_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      prev_r      <= '0;
      cnt_r       <= '0;
    end else begin
      if (out_ch.ready && state_r != S_SAT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            tpos_r  <= in_ch.goal_position;
            mpos_r  <= in_ch.measured_position;
            mvel_r  <= in_ch.measured_velocity;
            state_r <= S_PERR;
          end
        end
        S_PERR: begin
          perr_r  <= sat32(acc_t'(tpos_r) - acc_t'(mpos_r));
          state_r <= S_BAND1;
        end
        S_BAND1: begin
          band_r  <= in_band(perr_r, cfg.deadband);
          state_r <= S_MULV;
        end
        S_MULV: begin
          if (mul_done) begin
            tvel_r  <= band_r ? '0 : sat32(acc_t'(mul_res));
            state_r <= S_VERR;
          end
        end
        S_VERR: begin
          verr_r  <= sat32(acc_t'(tvel_r) - acc_t'(mvel_r));
          state_r <= S_BAND2;
        end
        S_BAND2: begin
          err_r   <= in_band(verr_r, cfg.deadband) ? '0 : verr_r;
          state_r <= S_INTEG;
        end
        S_INTEG: begin
          // clamp the integral, latch the error change, start the P product
          if (integ_sum > SUM_W'(INTEGRAL_LIMIT))
            integ_r <= INTEG_W'(INTEGRAL_LIMIT);
          else if (integ_sum < -SUM_W'(INTEGRAL_LIMIT))
            integ_r <= -INTEG_W'(INTEGRAL_LIMIT);
          else
            integ_r <= integ_sum[INTEG_W-1:0];
          diff_r  <= mul_x_t'(err_r) - mul_x_t'(prev_r);
          prev_r  <= err_r;
          acc_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_MULI;
        end
        S_MULI: begin
          state_r <= S_MULD;
        end
        S_MULD: begin
          state_r <= S_ACCW;
        end
        S_ACCW: begin
          if (mul_done) begin
            acc_r <= acc_r + acc_t'(mul_res);
            if (cnt_r == 2'd2) begin
              cnt_r   <= '0;
              state_r <= S_OFFS;
            end else begin
              cnt_r <= cnt_r + 2'd1;
            end
          end
        end
        S_OFFS: begin
          // zero counts as non-negative
          u_r     <= acc_r[ACC_W-1] ? acc_r - acc_t'(DEAD_ZONE_OFFSET)
                                    : acc_r + acc_t'(DEAD_ZONE_OFFSET);
          cnt_r   <= '0;
          state_r <= S_SAT;
        end
        S_SAT: begin
          // hold until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_drive_r <= u_sat[CURRENT_W-1:0];
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_PERR)
    else $error("accepted item did not start the sequence");

  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (integ_r <= INTEG_W'(INTEGRAL_LIMIT)) && (integ_r >= -INTEG_W'(INTEGRAL_LIMIT)))
    else $error("integral outside its clamp");

  a_term_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("more PID terms accumulated than issued");

endmodule
